### design/catmull_rom_point_and_tangent_unit_assert.svh
// assertion macros shared by the checker of the spline unit
// no dependencies
`ifndef CATMULL_ROM_POINT_AND_TANGENT_UNIT_ASSERT_SVH
`define CATMULL_ROM_POINT_AND_TANGENT_UNIT_ASSERT_SVH

// implication in the same cycle, masked while reset is held
`define CRPT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crpt assertion failed");

// implication in the next cycle, no reset mask
`define CRPT_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("crpt assertion failed");

`endif

### design/crpt_pkg.sv
// package of the catmull-rom point and tangent unit: word types, mode codes,
// parameter defaults and pipeline depth; no dependencies
package crpt_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int FRAC_BITS_DEF  = 16;

  // cycles from the accepting edge to the edge that takes the result
  localparam int PIPE_DEPTH = 7;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_POS  = 2'd1;
  localparam logic [1:0] MODE_TAN  = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [5:0]         point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [5:0]         segment;
    logic [15:0]        fraction;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
  } out_word_t;

endpackage

### design/catmull_rom_point_and_tangent_unit.sv
// top level of the catmull-rom point and tangent unit
// depends on crpt_pkg and crpt_ram
//
//   channel  dir  handshake                 word
//   in_      in   start high, busy low      in_word   (in_word_t)
//   out_     out  out_valid, one cycle      out_word  (out_word_t)
//
// one word enters every cycle while busy is low; an evaluate word gives its result
// after the stages for t^2 and t^3 (2 multiplies), weights, products, sum,
// rounding and saturation, and a load word is written at its accepting edge
// four copies of the point ram give the four point reads of each cycle
// busy is high only while reset is held; the tables need no clearing pass
// the receiver cannot stall, so nothing is ever held back
module catmull_rom_point_and_tangent_unit import crpt_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int IXW  = (AW > 6) ? AW : 6;
  localparam int F    = FRAC_BITS;
  localparam int FXW  = (F > 16) ? F : 16;
  localparam int WW   = F + 6;
  localparam int PW   = 32 + WW;
  localparam int SUMW = PW + 2;
  localparam int SW   = SUMW - (F + 1);

  localparam logic [2*F-1:0]         HALF    = (2*F)'(1) << (F - 1);
  localparam logic signed [WW-1:0]   ONE_W   = WW'(1) << F;
  localparam logic signed [SUMW-1:0] ROUND_S = SUMW'(1) << F;
  localparam logic signed [SW-1:0]   SAT_HI  = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0]   SAT_LO  = -SAT_HI - SW'(1);

  function automatic logic [AW-1:0] wrap_idx(input logic [6:0] v);
    logic [AW-1:0] r;
    r = '0;
    for (int i = 0; i < 128; i++) begin
      if (v == 7'(i)) begin
        r = AW'(i % MAX_POINTS);
      end
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
    logic signed [31:0] r;
    r = v[31:0];
    if (v > SAT_HI) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_LO) begin
      r = 32'sh80000000;
    end
    return r;
  endfunction

  logic accept;
  logic eval_acc;
  logic load_en;
  logic [IXW-1:0] pi_ext;
  logic [AW-1:0]  waddr;
  logic [63:0]    wdata;
  logic [AW-1:0]  raddr [4];
  logic [63:0]    rdata [4];

  assign busy     = !rst_n;
  assign accept   = start && !busy;
  assign eval_acc = accept && (in_word.mode == MODE_POS || in_word.mode == MODE_TAN);
  assign load_en  = accept && (in_word.mode == MODE_LOAD)
                    && (int'(in_word.point_index) < MAX_POINTS);
  assign pi_ext   = IXW'(in_word.point_index);
  assign waddr    = pi_ext[AW-1:0];
  assign wdata    = {in_word.point_x, in_word.point_y};

  for (genvar k = 0; k < 4; k++) begin : g_bank
    assign raddr[k] = wrap_idx(7'(in_word.segment) + 7'(k));
    crpt_ram #(
      .WIDTH (64),
      .DEPTH (MAX_POINTS)
    ) u_ram (
      .clk   (clk),
      .we    (load_en),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr[k]),
      .rdata (rdata[k])
    );
  end

  // stage 1: t squared
  logic [FXW-1:0] frac_ext;
  logic [F-1:0]   t_nxt;
  logic [2*F-1:0] tsq_nxt;
  logic           v1_r, tan1_r;
  logic [F-1:0]   t1_r;
  logic [2*F-1:0] tsq1_r;

  assign frac_ext = FXW'(in_word.fraction);
  assign t_nxt    = frac_ext[F-1:0];
  assign tsq_nxt  = (2*F)'(t_nxt) * (2*F)'(t_nxt);

  // stage 2: round t squared, take the points
  logic [2*F-1:0] ttsum;
  logic           v2_r, tan2_r;
  logic [F-1:0]   t2_r, tt2_r;
  logic signed [31:0] px2_r [4];
  logic signed [31:0] py2_r [4];

  assign ttsum = tsq1_r + HALF;

  // stage 3: t cubed
  logic [2*F-1:0] cub_nxt;
  logic           v3_r, tan3_r;
  logic [F-1:0]   t3_r, tt3_r;
  logic [2*F-1:0] cub3_r;
  logic signed [31:0] px3_r [4];
  logic signed [31:0] py3_r [4];

  assign cub_nxt = (2*F)'(tt2_r) * (2*F)'(t2_r);

  // stage 4: weights
  logic [2*F-1:0]        cubsum;
  logic signed [WW-1:0]  st, stt, sttt;
  logic signed [WW-1:0]  w_nxt [4];
  logic                  v4_r;
  logic signed [WW-1:0]  w4_r [4];
  logic signed [31:0]    px4_r [4];
  logic signed [31:0]    py4_r [4];

  assign cubsum = cub3_r + HALF;
  assign st     = WW'(t3_r);
  assign stt    = WW'(tt3_r);
  assign sttt   = WW'(cubsum[2*F-1:F]);

  always_comb begin
    if (tan3_r) begin
      w_nxt[0] = -((stt <<< 1) + stt) + (st <<< 2) - ONE_W;
      w_nxt[1] = (stt <<< 3) + stt - ((st <<< 3) + (st <<< 1));
      w_nxt[2] = -((stt <<< 3) + stt) + (st <<< 3) + ONE_W;
      w_nxt[3] = (stt <<< 1) + stt - (st <<< 1);
    end else begin
      w_nxt[0] = -sttt + (stt <<< 1) - st;
      w_nxt[1] = (sttt <<< 1) + sttt - ((stt <<< 2) + stt) + (ONE_W <<< 1);
      w_nxt[2] = -((sttt <<< 1) + sttt) + (stt <<< 2) + st;
      w_nxt[3] = sttt - stt;
    end
  end

  // stage 5: products
  logic signed [PW-1:0] prx_nxt [4];
  logic signed [PW-1:0] pry_nxt [4];
  logic                 v5_r;
  logic signed [PW-1:0] prx5_r [4];
  logic signed [PW-1:0] pry5_r [4];

  for (genvar k = 0; k < 4; k++) begin : g_mul
    assign prx_nxt[k] = PW'(px4_r[k]) * PW'(w4_r[k]);
    assign pry_nxt[k] = PW'(py4_r[k]) * PW'(w4_r[k]);
  end

  // stage 6: sums with rounding constant
  logic signed [SUMW-1:0] sx_nxt, sy_nxt;
  logic                   v6_r;
  logic signed [SUMW-1:0] sx6_r, sy6_r;

  assign sx_nxt = SUMW'(prx5_r[0]) + SUMW'(prx5_r[1]) + SUMW'(prx5_r[2])
                  + SUMW'(prx5_r[3]) + ROUND_S;
  assign sy_nxt = SUMW'(pry5_r[0]) + SUMW'(pry5_r[1]) + SUMW'(pry5_r[2])
                  + SUMW'(pry5_r[3]) + ROUND_S;

  // stage 7: halve, drop fraction, saturate
  logic signed [SUMW-1:0] shx, shy;
  out_word_t              out_word_nxt;
  logic                   out_valid_r;
  out_word_t              out_word_r;

  assign shx = sx6_r >>> (F + 1);
  assign shy = sy6_r >>> (F + 1);
  assign out_word_nxt.result_x = sat32(shx[SW-1:0]);
  assign out_word_nxt.result_y = sat32(shy[SW-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= eval_acc;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      out_valid_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    tan1_r <= (in_word.mode == MODE_TAN);
    t1_r   <= t_nxt;
    tsq1_r <= tsq_nxt;

    tan2_r <= tan1_r;
    t2_r   <= t1_r;
    tt2_r  <= ttsum[2*F-1:F];

    tan3_r <= tan2_r;
    t3_r   <= t2_r;
    tt3_r  <= tt2_r;
    cub3_r <= cub_nxt;

    for (int k = 0; k < 4; k++) begin
      px2_r[k]  <= rdata[k][63:32];
      py2_r[k]  <= rdata[k][31:0];
      px3_r[k]  <= px2_r[k];
      py3_r[k]  <= py2_r[k];
      px4_r[k]  <= px3_r[k];
      py4_r[k]  <= py3_r[k];
      w4_r[k]   <= w_nxt[k];
      prx5_r[k] <= prx_nxt[k];
      pry5_r[k] <= pry_nxt[k];
    end

    sx6_r      <= sx_nxt;
    sy6_r      <= sy_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

### design/crpt_ram.sv
// generic simple dual-port ram, one write and one registered read port
// depends on crpt_pkg for defaults
module crpt_ram import crpt_pkg::*; #(
  parameter int WIDTH = 64,
  parameter int DEPTH = MAX_POINTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/crpt_checker.sv
// port-level checker of the catmull-rom point and tangent unit, with its bind
// depends on crpt_pkg and catmull_rom_point_and_tangent_unit_assert.svh
`include "catmull_rom_point_and_tangent_unit_assert.svh"

module crpt_checker import crpt_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input in_word_t in_word,
  input logic     out_valid
);

  logic eval_acc;
  logic load_acc;

  assign eval_acc = start && !busy
                    && (in_word.mode == MODE_POS || in_word.mode == MODE_TAN);
  assign load_acc = start && !busy && (in_word.mode == MODE_LOAD);

  `CRPT_ASSERT_NEXT(a_reset_quiet, clk, !rst_n, !out_valid)
  `CRPT_ASSERT_SAME(a_eval_gives_word, clk, rst_n, eval_acc, ##PIPE_DEPTH out_valid)
  `CRPT_ASSERT_SAME(a_load_gives_none, clk, rst_n, load_acc, ##PIPE_DEPTH !out_valid)
  `CRPT_ASSERT_SAME(a_word_has_cause, clk, rst_n, out_valid, $past(eval_acc, PIPE_DEPTH))

endmodule

bind catmull_rom_point_and_tangent_unit crpt_checker u_crpt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_word   (in_word),
  .out_valid (out_valid)
);
